// ----- design/tcca_pkg.sv -----
// tcca_pkg: shared types and constants of the three-channel calibrated average unit
// no dependencies
`timescale 1ns / 1ps

package tcca_pkg;

   localparam int CH_W       = 2;
   localparam int CH_COUNT   = 3;
   localparam int SAMPLE_W   = 10;
   localparam int CFG_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CAL_W      = 14;
   localparam int SUM_W      = 20;
   localparam int PROD_W     = 26;
   localparam int ACC_W      = 28;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CAL_W-1:0] CAL_MAX = 14'd16383;

   localparam logic [CFG_W-1:0] GAIN_A_RST   = 16'd6192;
   localparam logic [CFG_W-1:0] OFFSET_A_RST = 16'hFB89;   // -1143
   localparam logic [CFG_W-1:0] GAIN_B_RST   = 16'd6206;
   localparam logic [CFG_W-1:0] OFFSET_B_RST = 16'd209;
   localparam logic [CFG_W-1:0] GAIN_V_RST   = 16'd23722;
   localparam logic [CFG_W-1:0] OFFSET_V_RST = 16'hFD2D;   // -723

   typedef enum logic [CH_W-1:0] {
      CH_CURRENT_A = 2'd0,
      CH_CURRENT_B = 2'd1,
      CH_VOLTAGE   = 2'd2
   } channel_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_A   = 3'd0,
      CSR_OFFSET_A = 3'd1,
      CSR_GAIN_B   = 3'd2,
      CSR_OFFSET_B = 3'd3,
      CSR_GAIN_V   = 3'd4,
      CSR_OFFSET_V = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic                 vld;
      logic [CSR_IDX_W-1:0] index;
      logic [CFG_W-1:0]     data;
   } csr_wr_type;

   typedef struct packed {
      logic [CH_W-1:0]  updated_channel;
      logic [CAL_W-1:0] current_a_avg;
      logic [CAL_W-1:0] current_b_avg;
      logic [CAL_W-1:0] voltage_avg;
   } rsp_type;

endpackage

// ----- design/tcca_fifo.sv -----
// tcca_fifo: small register queue with push/full and pop/empty sides
// depends on nothing; used between front and back and on the result side
`timescale 1ns / 1ps

module tcca_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ----- design/tcca_front.sv -----
// tcca_front: takes samples and tags each with its channel and ring slot
// depends on tcca_pkg; feeds the front queue
`timescale 1ns / 1ps

module tcca_front #(
   parameter int WINDOW = 50
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic [tcca_pkg::SAMPLE_W-1:0] sample,
   output logic                         q_push,
   input  logic                         q_full,
   output logic [tcca_pkg::CH_W-1:0]    q_ch,
   output logic [$clog2(WINDOW)-1:0]    q_slot,
   output logic [tcca_pkg::SAMPLE_W-1:0] q_sample
);

   localparam int SLOT_W = $clog2(WINDOW);

   logic [tcca_pkg::CH_W-1:0] turn_ff, turn_in;
   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic                      take;

   assign full     = q_full;
   assign take     = push && !q_full;
   assign q_push   = take;
   assign q_ch     = turn_ff;
   assign q_slot   = slot_ff;
   assign q_sample = sample;

   always_comb begin
      turn_in = turn_ff;
      slot_in = slot_ff;
      if (take) begin
         case (turn_ff)
            tcca_pkg::CH_CURRENT_A: turn_in = tcca_pkg::CH_CURRENT_B;
            tcca_pkg::CH_CURRENT_B: turn_in = tcca_pkg::CH_VOLTAGE;
            default: begin
               turn_in = tcca_pkg::CH_CURRENT_A;
               slot_in = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + SLOT_W'(1);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_ff <= tcca_pkg::CH_CURRENT_A;
         slot_ff <= '0;
      end else begin
         turn_ff <= turn_in;
         slot_ff <= slot_in;
      end
   end

endmodule

// ----- design/tcca_back.sv -----
// tcca_back: calibration, ring update, running sums and window averages
// depends on tcca_pkg; pops the front queue, pushes the result queue
`timescale 1ns / 1ps

module tcca_back #(
   parameter int WINDOW = 50
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tcca_pkg::csr_wr_type          csr,
   input  logic                          in_empty,
   output logic                          in_pop,
   input  logic [tcca_pkg::CH_W-1:0]     in_ch,
   input  logic [$clog2(WINDOW)-1:0]     in_slot,
   input  logic [tcca_pkg::SAMPLE_W-1:0] in_sample,
   input  logic                          out_full,
   output logic                          out_push,
   output tcca_pkg::rsp_type             out_rsp
);

   localparam int SLOT_W  = $clog2(WINDOW);
   localparam int SUM_W   = tcca_pkg::SUM_W;
   localparam int CAL_W   = tcca_pkg::CAL_W;
   localparam int CH_W    = tcca_pkg::CH_W;
   localparam int ACC_W   = tcca_pkg::ACC_W;
   localparam int SHIFT   = SUM_W + $clog2(WINDOW);
   localparam int RECIP_W = SUM_W + 1;
   localparam int MUL_W   = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

   // calibration registers
   logic [tcca_pkg::CFG_W-1:0] gain_ff   [tcca_pkg::CH_COUNT];
   logic [tcca_pkg::CFG_W-1:0] offset_ff [tcca_pkg::CH_COUNT];

   // ring storage and per-entry valid bits
   logic [CAL_W-1:0]  ring_mem    [tcca_pkg::CH_COUNT][WINDOW];
   logic [WINDOW-1:0] ring_vld_ff [tcca_pkg::CH_COUNT];

   logic [SUM_W-1:0] sum_ff [tcca_pkg::CH_COUNT];
   logic [CAL_W-1:0] avg_ff [tcca_pkg::CH_COUNT];

   logic                  adv;
   logic [CH_W-1:0]       ch_idx;
   logic [tcca_pkg::PROD_W-1:0] prod;
   logic [ACC_W-1:0]      acc_in;

   logic                  s1_vld_ff;
   logic [CH_W-1:0]       s1_ch_ff;
   logic [SLOT_W-1:0]     s1_slot_ff;
   logic [ACC_W-1:0]      s1_acc_ff;
   logic [CAL_W-1:0]      s1_old_ff;
   logic                  s1_oldv_ff;

   logic [CAL_W-1:0]      cal_in;
   logic [CAL_W-1:0]      old_val;
   logic [SUM_W-1:0]      sum_in;

   logic                  s2_vld_ff;
   logic [CH_W-1:0]       s2_ch_ff;
   logic [SUM_W-1:0]      s2_sum_ff;

   logic [MUL_W-1:0]      mul_in;
   logic                  s3_vld_ff;
   logic [CH_W-1:0]       s3_ch_ff;
   logic [MUL_W-1:0]      s3_prod_ff;
   logic [CAL_W-1:0]      quot;

   // whole pipe moves together; stalls only when the last stage cannot unload
   assign adv      = !s3_vld_ff || !out_full;
   assign in_pop   = adv && !in_empty;
   assign out_push = s3_vld_ff && !out_full;

   // stage 1: scaled sample plus offset, old ring entry read
   always_comb begin
      ch_idx = (in_ch == tcca_pkg::CH_CURRENT_B || in_ch == tcca_pkg::CH_VOLTAGE) ?
               in_ch : CH_W'(tcca_pkg::CH_CURRENT_A);
      prod   = tcca_pkg::PROD_W'(in_sample) * tcca_pkg::PROD_W'(gain_ff[ch_idx]);
      acc_in = ACC_W'({2'b00, prod}) +
               {{4{offset_ff[ch_idx][tcca_pkg::CFG_W-1]}}, offset_ff[ch_idx], 8'h00};
   end

   // stage 2: clamp, sum update
   always_comb begin
      if (s1_acc_ff[ACC_W-1]) begin
         cal_in = '0;
      end else if (s1_acc_ff[ACC_W-2:12] > 15'(tcca_pkg::CAL_MAX)) begin
         cal_in = tcca_pkg::CAL_MAX;
      end else begin
         cal_in = s1_acc_ff[CAL_W+11:12];
      end
      old_val = s1_oldv_ff ? s1_old_ff : '0;
      sum_in  = sum_ff[s1_ch_ff] - SUM_W'(old_val) + SUM_W'(cal_in);
   end

   // stage 3: divide by the window through a reciprocal multiply
   assign mul_in = MUL_W'(s2_sum_ff) * MUL_W'(RECIP);
   assign quot   = s3_prod_ff[SHIFT +: CAL_W];

   always_comb begin
      out_rsp.updated_channel = s3_ch_ff;
      out_rsp.current_a_avg = (s3_ch_ff == tcca_pkg::CH_CURRENT_A) ? quot : avg_ff[0];
      out_rsp.current_b_avg = (s3_ch_ff == tcca_pkg::CH_CURRENT_B) ? quot : avg_ff[1];
      out_rsp.voltage_avg   = (s3_ch_ff == tcca_pkg::CH_VOLTAGE)   ? quot : avg_ff[2];
   end

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff[0]   <= tcca_pkg::GAIN_A_RST;
         offset_ff[0] <= tcca_pkg::OFFSET_A_RST;
         gain_ff[1]   <= tcca_pkg::GAIN_B_RST;
         offset_ff[1] <= tcca_pkg::OFFSET_B_RST;
         gain_ff[2]   <= tcca_pkg::GAIN_V_RST;
         offset_ff[2] <= tcca_pkg::OFFSET_V_RST;
      end else if (csr.vld) begin
         case (csr.index)
            tcca_pkg::CSR_GAIN_A:   gain_ff[0]   <= csr.data;
            tcca_pkg::CSR_OFFSET_A: offset_ff[0] <= csr.data;
            tcca_pkg::CSR_GAIN_B:   gain_ff[1]   <= csr.data;
            tcca_pkg::CSR_OFFSET_B: offset_ff[1] <= csr.data;
            tcca_pkg::CSR_GAIN_V:   gain_ff[2]   <= csr.data;
            tcca_pkg::CSR_OFFSET_V: offset_ff[2] <= csr.data;
            default: ;
         endcase
      end
   end

   // ring memory: read for the incoming beat, write back in stage 2
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_old_ff <= ring_mem[ch_idx][in_slot];
         if (s1_vld_ff) begin
            ring_mem[s1_ch_ff][s1_slot_ff] <= cal_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < tcca_pkg::CH_COUNT; c++) begin
            ring_vld_ff[c] <= '0;
            sum_ff[c]      <= '0;
            avg_ff[c]      <= '0;
         end
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         if (adv) begin
            s1_vld_ff <= !in_empty;
            s2_vld_ff <= s1_vld_ff;
            s3_vld_ff <= s2_vld_ff;
            if (s1_vld_ff) begin
               ring_vld_ff[s1_ch_ff][s1_slot_ff] <= 1'b1;
               sum_ff[s1_ch_ff] <= sum_in;
            end
         end
         if (out_push) begin
            avg_ff[s3_ch_ff] <= quot;
         end
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ch_ff   <= ch_idx;
         s1_slot_ff <= in_slot;
         s1_acc_ff  <= acc_in;
         s1_oldv_ff <= ring_vld_ff[ch_idx][in_slot];
         s2_ch_ff   <= s1_ch_ff;
         s2_sum_ff  <= sum_in;
         s3_ch_ff   <= s2_ch_ff;
         s3_prod_ff <= mul_in;
      end
   end

endmodule

// ----- design/three_channel_calibrated_average_unit.sv -----
// three_channel_calibrated_average_unit: top level of the calibrated moving average
// depends on tcca_pkg, tcca_front, tcca_fifo, tcca_back
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   request  | push / full          | req_sample
//   response | empty / pop          | rsp_updated_channel, rsp_*_avg
//   csr      | csr_valid/csr_ready  | csr_index, csr_data
//
// one sample per cycle sustained while the result side keeps unloading; a result passes the front queue,
// three back stages (multiply-add, ring and sum update, reciprocal multiply) and then the result queue
// reset is synchronous; rings, sums and calibration registers come up at once, no sweep
// a stalled result side fills the result queue, then the back stages, then the front
// queue, after which full rises; csr_ready is always high
`timescale 1ns / 1ps

module three_channel_calibrated_average_unit #(
   parameter int WINDOW = 50
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [tcca_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                           empty,
   input  logic                           pop,
   output logic [tcca_pkg::CH_W-1:0]      rsp_updated_channel,
   output logic [tcca_pkg::CAL_W-1:0]     rsp_current_a_avg,
   output logic [tcca_pkg::CAL_W-1:0]     rsp_current_b_avg,
   output logic [tcca_pkg::CAL_W-1:0]     rsp_voltage_avg,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tcca_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tcca_pkg::CFG_W-1:0]     csr_data
);

   localparam int SLOT_W = $clog2(WINDOW);
   localparam int ITEM_W = SLOT_W + tcca_pkg::CH_W + tcca_pkg::SAMPLE_W;
   localparam int RSP_W  = $bits(tcca_pkg::rsp_type);

   logic                          fq_push, fq_full, fq_pop, fq_empty;
   logic [tcca_pkg::CH_W-1:0]     fr_ch, bk_ch;
   logic [SLOT_W-1:0]             fr_slot, bk_slot;
   logic [tcca_pkg::SAMPLE_W-1:0] fr_sample, bk_sample;
   logic [ITEM_W-1:0]             fq_rdata;
   tcca_pkg::csr_wr_type          csr_wr;
   logic                          rq_push, rq_full;
   tcca_pkg::rsp_type             bk_rsp, rq_rsp;
   logic [RSP_W-1:0]              rq_rdata;

   assign csr_ready    = 1'b1;
   assign csr_wr.vld   = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   tcca_front #(.WINDOW(WINDOW)) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .sample   (req_sample),
      .q_push   (fq_push),
      .q_full   (fq_full),
      .q_ch     (fr_ch),
      .q_slot   (fr_slot),
      .q_sample (fr_sample)
   );

   tcca_fifo #(.WIDTH(ITEM_W), .DEPTH(tcca_pkg::QUEUE_DEPTH)) u_front_q (
      .clock (clock),
      .reset (reset),
      .push  (fq_push),
      .full  (fq_full),
      .wdata ({fr_slot, fr_ch, fr_sample}),
      .pop   (fq_pop),
      .empty (fq_empty),
      .rdata (fq_rdata)
   );

   assign {bk_slot, bk_ch, bk_sample} = fq_rdata;

   tcca_back #(.WINDOW(WINDOW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_wr),
      .in_empty  (fq_empty),
      .in_pop    (fq_pop),
      .in_ch     (bk_ch),
      .in_slot   (bk_slot),
      .in_sample (bk_sample),
      .out_full  (rq_full),
      .out_push  (rq_push),
      .out_rsp   (bk_rsp)
   );

   tcca_fifo #(.WIDTH(RSP_W), .DEPTH(tcca_pkg::QUEUE_DEPTH)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rq_push),
      .full  (rq_full),
      .wdata (bk_rsp),
      .pop   (pop),
      .empty (empty),
      .rdata (rq_rdata)
   );

   assign rq_rsp              = rq_rdata;
   assign rsp_updated_channel = rq_rsp.updated_channel;
   assign rsp_current_a_avg   = rq_rsp.current_a_avg;
   assign rsp_current_b_avg   = rq_rsp.current_b_avg;
   assign rsp_voltage_avg     = rq_rsp.voltage_avg;

endmodule

// ----- verif/three_channel_calibrated_average_unit_test.sv -----
// three_channel_calibrated_average_unit_test: self-checking bench of the calibrated average unit
// a queue-fed driver and a checking monitor, a local averaging predictor, phased csr settings
// depends on tcca_pkg and three_channel_calibrated_average_unit
`timescale 1ns / 1ps

module three_channel_calibrated_average_unit_test;

   localparam int WINDOW = 50;
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_BEATS = 136;
   localparam int HOLD_AFTER_BEATS = 350;
   localparam int HOLD_CYCLES = 80;
   localparam logic [tcca_pkg::CSR_IDX_W-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [tcca_pkg::CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;
   localparam logic [tcca_pkg::SAMPLE_W-1:0] DIRECTED_SAMPLES [24] = '{
      10'd0, 10'd0, 10'd0, 10'd1023, 10'd1023, 10'd1023, 10'd512, 10'd1, 10'd700,
      10'd1023, 10'd1023, 10'd1023, 10'd0, 10'd0, 10'd0, 10'd1000, 10'd512, 10'd341,
      10'd1023, 10'd1023, 10'd1023, 10'd0, 10'd682, 10'd1
   };

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           push = 1'b0;
   logic                           full;
   logic [tcca_pkg::SAMPLE_W-1:0]  req_sample = '0;
   logic                           empty;
   logic                           pop = 1'b0;
   logic [tcca_pkg::CH_W-1:0]      rsp_updated_channel;
   logic [tcca_pkg::CAL_W-1:0]     rsp_current_a_avg;
   logic [tcca_pkg::CAL_W-1:0]     rsp_current_b_avg;
   logic [tcca_pkg::CAL_W-1:0]     rsp_voltage_avg;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [tcca_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [tcca_pkg::CFG_W-1:0]     csr_data = '0;

   logic [tcca_pkg::SAMPLE_W-1:0] pending_samples [$];
   tcca_pkg::rsp_type             expected_averages [$];
   int                            accepted_count = 0;
   int                            fail_count = 0;
   int                            send_gap = 0;
   int                            drain_gap = 0;
   logic                          hold_rsp = 1'b0;
   logic                          no_idle = 1'b0;

   // predictor state
   tcca_pkg::channel_type             turn_q = tcca_pkg::CH_CURRENT_A;
   int                                slot_q = 0;
   logic [tcca_pkg::CAL_W-1:0]        ring_q [tcca_pkg::CH_COUNT][WINDOW];
   logic [tcca_pkg::SUM_W-1:0]        sum_q [tcca_pkg::CH_COUNT];
   logic [tcca_pkg::CFG_W-1:0]        gain_q [tcca_pkg::CH_COUNT];
   logic signed [tcca_pkg::CFG_W-1:0] offset_q [tcca_pkg::CH_COUNT];

   three_channel_calibrated_average_unit #(.WINDOW(WINDOW)) uut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_sample(req_sample),
      .empty(empty),
      .pop(pop),
      .rsp_updated_channel(rsp_updated_channel),
      .rsp_current_a_avg(rsp_current_a_avg),
      .rsp_current_b_avg(rsp_current_b_avg),
      .rsp_voltage_avg(rsp_voltage_avg),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [tcca_pkg::CAL_W-1:0] calibrate(
         input logic [tcca_pkg::SAMPLE_W-1:0] smp,
         input logic [tcca_pkg::CFG_W-1:0] gain,
         input logic signed [tcca_pkg::CFG_W-1:0] ofs);
      longint acc;
      acc = longint'(smp) * longint'(gain) + longint'(ofs) * 256;
      if (acc < 0) return '0;
      acc = acc >>> 12;
      if (acc > 16383) return tcca_pkg::CAL_MAX;
      return acc[tcca_pkg::CAL_W-1:0];
   endfunction

   function automatic tcca_pkg::rsp_type predict_averages(
         input logic [tcca_pkg::SAMPLE_W-1:0] smp);
      logic [tcca_pkg::CAL_W-1:0] cal;
      tcca_pkg::rsp_type          r;
      cal = calibrate(smp, gain_q[turn_q], offset_q[turn_q]);
      sum_q[turn_q] = sum_q[turn_q] - tcca_pkg::SUM_W'(ring_q[turn_q][slot_q])
                      + tcca_pkg::SUM_W'(cal);
      ring_q[turn_q][slot_q] = cal;
      r.updated_channel = turn_q;
      case (turn_q)
         tcca_pkg::CH_CURRENT_A: turn_q = tcca_pkg::CH_CURRENT_B;
         tcca_pkg::CH_CURRENT_B: turn_q = tcca_pkg::CH_VOLTAGE;
         default: begin
            turn_q = tcca_pkg::CH_CURRENT_A;
            slot_q = (slot_q + 1 >= WINDOW) ? 0 : slot_q + 1;
         end
      endcase
      r.current_a_avg = tcca_pkg::CAL_W'(sum_q[tcca_pkg::CH_CURRENT_A] / WINDOW);
      r.current_b_avg = tcca_pkg::CAL_W'(sum_q[tcca_pkg::CH_CURRENT_B] / WINDOW);
      r.voltage_avg   = tcca_pkg::CAL_W'(sum_q[tcca_pkg::CH_VOLTAGE] / WINDOW);
      return r;
   endfunction

   function automatic void note_csr_write(input logic [tcca_pkg::CSR_IDX_W-1:0] idx,
                                          input logic [tcca_pkg::CFG_W-1:0] val);
      case (idx)
         tcca_pkg::CSR_GAIN_A:   gain_q[tcca_pkg::CH_CURRENT_A] = val;
         tcca_pkg::CSR_OFFSET_A: offset_q[tcca_pkg::CH_CURRENT_A] = val;
         tcca_pkg::CSR_GAIN_B:   gain_q[tcca_pkg::CH_CURRENT_B] = val;
         tcca_pkg::CSR_OFFSET_B: offset_q[tcca_pkg::CH_CURRENT_B] = val;
         tcca_pkg::CSR_GAIN_V:   gain_q[tcca_pkg::CH_VOLTAGE] = val;
         tcca_pkg::CSR_OFFSET_V: offset_q[tcca_pkg::CH_VOLTAGE] = val;
         default: ;
      endcase
   endfunction

   // mostly short gaps, a few long ones
   function automatic int draw_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [tcca_pkg::SAMPLE_W-1:0] draw_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return tcca_pkg::SAMPLE_W'($urandom_range(0, 1023));
   endfunction

   function automatic logic [tcca_pkg::CFG_W-1:0] draw_gain();
      int r;
      r = $urandom_range(0, 19);
      if (r < 3) return 16'd0;
      if (r < 6) return 16'hFFFF;
      return tcca_pkg::CFG_W'($urandom_range(0, 65535));
   endfunction

   function automatic logic [tcca_pkg::CFG_W-1:0] draw_offset();
      int r;
      r = $urandom_range(0, 19);
      if (r < 3) return 16'h8000;
      if (r < 6) return 16'h7FFF;
      return tcca_pkg::CFG_W'($urandom_range(0, 65535));
   endfunction

   task automatic check_field(input string name, input logic [tcca_pkg::CAL_W-1:0] want,
                              input logic [tcca_pkg::CAL_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   // sample driver
   always @(posedge clock) begin
      logic                          n_push;
      logic [tcca_pkg::SAMPLE_W-1:0] n_sample;
      if (reset) begin
         push <= 1'b0;
         send_gap = 0;
      end else begin
         n_push = push;
         n_sample = req_sample;
         if (push && !full) begin
            expected_averages.push_back(predict_averages(req_sample));
            accepted_count <= accepted_count + 1;
            send_gap = draw_gap();
            n_push = 1'b0;
         end
         if (!n_push) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_samples.size() != 0) begin
               n_push = 1'b1;
               n_sample = pending_samples.pop_front();
            end
         end
         push <= n_push;
         req_sample <= n_sample;
      end
   end

   // result monitor
   always @(posedge clock) begin
      tcca_pkg::rsp_type want;
      if (reset) begin
         pop <= 1'b0;
         drain_gap = 0;
      end else begin
         if (pop && !empty) begin
            if (expected_averages.size() == 0) begin
               $error("result beat with no expectation waiting");
               fail_count++;
            end else begin
               want = expected_averages.pop_front();
               check_field("updated_channel", tcca_pkg::CAL_W'(want.updated_channel),
                           tcca_pkg::CAL_W'(rsp_updated_channel));
               check_field("current_a_avg", want.current_a_avg, rsp_current_a_avg);
               check_field("current_b_avg", want.current_b_avg, rsp_current_b_avg);
               check_field("voltage_avg", want.voltage_avg, rsp_voltage_avg);
            end
            drain_gap = draw_gap();
         end
         if (hold_rsp) begin
            pop <= 1'b0;
         end else if (drain_gap > 0) begin
            pop <= 1'b0;
            drain_gap--;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // long result stall while samples keep coming, so full must rise
   initial begin
      wait (accepted_count >= HOLD_AFTER_BEATS);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #3_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic write_csr(input logic [tcca_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tcca_pkg::CFG_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      note_csr_write(idx, val);
      csr_valid <= 1'b0;
   endtask

   task automatic load_calibration(input logic [tcca_pkg::CFG_W-1:0] ga, oa, gb, ob, gv, ov);
      write_csr(tcca_pkg::CSR_GAIN_A, ga);
      write_csr(tcca_pkg::CSR_OFFSET_A, oa);
      write_csr(tcca_pkg::CSR_GAIN_B, gb);
      write_csr(tcca_pkg::CSR_OFFSET_B, ob);
      write_csr(tcca_pkg::CSR_GAIN_V, gv);
      write_csr(tcca_pkg::CSR_OFFSET_V, ov);
   endtask

   task automatic queue_directed(input int first, input int count);
      @(negedge clock);
      for (int i = first; i < first + count; i++) pending_samples.push_back(DIRECTED_SAMPLES[i]);
   endtask

   task automatic queue_random(input int count);
      @(negedge clock);
      repeat (count) pending_samples.push_back(draw_sample());
   endtask

   task automatic settle();
      do @(negedge clock);
      while (pending_samples.size() != 0 || push || expected_averages.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   initial begin
      for (int c = 0; c < tcca_pkg::CH_COUNT; c++) begin
         sum_q[c] = '0;
         for (int s = 0; s < WINDOW; s++) ring_q[c][s] = '0;
      end
      gain_q[tcca_pkg::CH_CURRENT_A] = 16'd6192;
      offset_q[tcca_pkg::CH_CURRENT_A] = -16'sd1143;
      gain_q[tcca_pkg::CH_CURRENT_B] = 16'd6206;
      offset_q[tcca_pkg::CH_CURRENT_B] = 16'sd209;
      gain_q[tcca_pkg::CH_VOLTAGE] = 16'd23722;
      offset_q[tcca_pkg::CH_VOLTAGE] = -16'sd723;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset calibration, partly filled rings, negative calibrated values clamp to zero
      queue_directed(0, 9);
      settle();

      // largest gains and offsets saturate; writes past the last register change nothing
      load_calibration(16'hFFFF, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'hFFFF, 16'h7FFF);
      write_csr(CSR_UNUSED_LO, 16'h1234);
      write_csr(CSR_UNUSED_HI, 16'h8001);
      queue_directed(9, 9);
      settle();

      // zero gains with most negative offsets
      load_calibration(16'h0000, 16'h8000, 16'h0000, 16'h8000, 16'h0000, 16'h8000);
      queue_directed(18, 6);
      settle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 3)
            load_calibration(16'h0000, 16'h7FFF, 16'hFFFF, 16'h8000, 16'hFFFF, 16'h7FFF);
         else
            load_calibration(draw_gain(), draw_offset(), draw_gain(), draw_offset(),
                             draw_gain(), draw_offset());
         @(negedge clock);
         no_idle <= (phase == 1);
         if (phase == 4) begin
            queue_random(PHASE_BEATS / 2);
            settle();
            queue_random(PHASE_BEATS - PHASE_BEATS / 2);
         end else begin
            queue_random(PHASE_BEATS);
         end
         settle();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0 && expected_averages.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
